@@ sv/oelt_pkg.sv @@
// shared types, codes and default sizes for the ordered edge list table
package oelt_pkg;

	localparam int unsigned LIST_DEPTH_DEF  = 64;
	localparam int unsigned VERTEX_BITS_DEF = 12;

	// operation kinds
	localparam logic [1:0] KIND_FRONT  = 2'd0;
	localparam logic [1:0] KIND_BACK   = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;
	localparam logic [1:0] KIND_REMOVE = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        vertex;
		logic [15:0]        capacity;
		logic signed [15:0] cost;
	} op_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         position;
		logic [15:0]        found_capacity;
		logic signed [15:0] found_cost;
		logic [6:0]         entry_count;
		logic               is_empty;
	} res_t;

endpackage

@@ sv/oelt_store.sv @@
// entry store: one write port, one read port with registered read data
module oelt_store #(
	parameter int unsigned DEPTH = oelt_pkg::LIST_DEPTH_DEF,
	parameter int unsigned WIDTH = oelt_pkg::VERTEX_BITS_DEF + 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ordered_edge_list_table.sv @@
// top level of the ordered edge list table: sequencer around the entry store
//
// The block keeps up to LIST_DEPTH adjacency entries (vertex, capacity, cost)
// in list order in a single-port-read, single-port-write store, index 0 being
// the front. One operation beat goes in on op, one result beat comes out on
// res for every operation. The block takes one operation at a time: op_ready
// is high only while the sequencer is idle. A front insert moves every entry
// up by one, one entry a cycle. A search compares one entry a cycle from the
// front. A removal first searches, then moves the entries behind the hit down
// by one, one a cycle. The single read port of the entry store is why entries
// go one at a time: every entry that is compared or moved goes through it
// once. A finished result sits in an output register; if the previous result
// has not been taken yet, the block waits there before going idle. An insert
// into a full list reports list full and leaves the list alone; a search or
// removal without a match reports not found with position, capacity and cost
// of zero. Duplicate vertices are allowed and the first one from the front is
// used. The store needs no clearing after reset: only entries below the count
// are ever used.
module ordered_edge_list_table #(
	parameter int unsigned LIST_DEPTH  = oelt_pkg::LIST_DEPTH_DEF,
	parameter int unsigned VERTEX_BITS = oelt_pkg::VERTEX_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	output logic            op_ready,
	input  oelt_pkg::op_t   op,
	output logic            res_valid,
	input  logic            res_ready,
	output oelt_pkg::res_t  res
);

	localparam int unsigned AW = $clog2(LIST_DEPTH);      // store address bits
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);  // count bits
	localparam int unsigned EW = VERTEX_BITS + 32;        // entry word bits

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRONT_RD,
		ST_FRONT_WR,
		ST_PUT,
		ST_SEARCH_RD,
		ST_SEARCH_CMP,
		ST_REMOVE_WR,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic [AW-1:0]          pos_q;
	logic [1:0]             status_q;
	logic [15:0]            fcap_q;
	logic [15:0]            fcost_q;
	logic [1:0]             kind_q;
	logic [VERTEX_BITS-1:0] vtx_q;
	logic [15:0]            cap_q;
	logic [15:0]            cost_q;
	logic                   res_valid_q;
	oelt_pkg::res_t         res_q;

	// vertex masked or widened to the stored width
	logic [VERTEX_BITS+11:0] vtx_ext;
	logic [VERTEX_BITS-1:0]  vtx_in;

	// store port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [CW-1:0] rd_idx;
	logic [EW-1:0] mem_rdata;

	// fields of the entry just read
	logic [VERTEX_BITS-1:0] rd_vtx;
	logic [15:0]            rd_cap;
	logic [15:0]            rd_cost;
	logic                   rd_match;

	// result fields narrowed to the port widths
	logic [AW+5:0] pos_ext;
	logic [CW+6:0] cnt_ext;

	assign vtx_ext = {{VERTEX_BITS{1'b0}}, op.vertex};
	assign vtx_in  = vtx_ext[VERTEX_BITS-1:0];

	assign rd_vtx   = mem_rdata[EW-1:32];
	assign rd_cap   = mem_rdata[31:16];
	assign rd_cost  = mem_rdata[15:0];
	assign rd_match = (rd_vtx == vtx_q);

	assign pos_ext = {6'd0, pos_q};
	assign cnt_ext = {7'd0, cnt_q};

	// read address runs one step ahead of the entry being used
	always_comb begin
		case (state_q)
			ST_FRONT_RD:   rd_idx = idx_q - CW'(1);
			ST_FRONT_WR:   rd_idx = idx_q - CW'(2);
			ST_SEARCH_CMP: rd_idx = idx_q + CW'(1);
			ST_REMOVE_WR:  rd_idx = idx_q + CW'(2);
			default:       rd_idx = idx_q;
		endcase
	end

	// writes: moved entry while shifting, new entry on put
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			ST_FRONT_WR: begin
				mem_we = 1'b1;
			end
			ST_REMOVE_WR: begin
				mem_we = 1'b1;
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = {vtx_q, cap_q, cost_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	oelt_store #(
		.DEPTH (LIST_DEPTH),
		.WIDTH (EW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_idx[AW-1:0]),
		.rdata (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			status_q    <= oelt_pkg::STATUS_OK;
			fcap_q      <= '0;
			fcost_q     <= '0;
			kind_q      <= oelt_pkg::KIND_FRONT;
			vtx_q       <= '0;
			cap_q       <= '0;
			cost_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// beat taken; a new one loaded in the done state keeps valid up
			if (res_valid_q && res_ready && state_q != ST_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						kind_q   <= op.kind;
						vtx_q    <= vtx_in;
						cap_q    <= op.capacity;
						cost_q   <= op.cost;
						pos_q    <= '0;
						fcap_q   <= '0;
						fcost_q  <= '0;
						if (op.kind inside {oelt_pkg::KIND_FRONT, oelt_pkg::KIND_BACK}) begin
							idx_q <= cnt_q;
							if (cnt_q == CW'(LIST_DEPTH)) begin
								status_q <= oelt_pkg::STATUS_FULL;
								state_q  <= ST_DONE;
							end else begin
								status_q <= oelt_pkg::STATUS_OK;
								if (op.kind == oelt_pkg::KIND_FRONT && cnt_q != '0) begin
									state_q <= ST_FRONT_RD;
								end else begin
									state_q <= ST_PUT;
								end
							end
						end else begin
							idx_q <= '0;
							if (cnt_q == '0) begin
								status_q <= oelt_pkg::STATUS_MISSING;
								state_q  <= ST_DONE;
							end else begin
								status_q <= oelt_pkg::STATUS_OK;
								state_q  <= ST_SEARCH_RD;
							end
						end
					end
				end
				ST_FRONT_RD: begin
					state_q <= ST_FRONT_WR;
				end
				ST_FRONT_WR: begin
					// entry idx-1 lands at idx
					idx_q <= idx_q - CW'(1);
					if (idx_q == CW'(1)) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					pos_q   <= idx_q[AW-1:0];
					cnt_q   <= cnt_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_SEARCH_RD: begin
					state_q <= ST_SEARCH_CMP;
				end
				ST_SEARCH_CMP: begin
					if (rd_match) begin
						pos_q   <= idx_q[AW-1:0];
						fcap_q  <= rd_cap;
						fcost_q <= rd_cost;
						if (kind_q != oelt_pkg::KIND_REMOVE) begin
							state_q <= ST_DONE;
						end else if (idx_q + CW'(1) == cnt_q) begin
							// hit was the last entry: nothing to close up
							cnt_q   <= cnt_q - CW'(1);
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_REMOVE_WR;
						end
					end else if (idx_q + CW'(1) == cnt_q) begin
						status_q <= oelt_pkg::STATUS_MISSING;
						state_q  <= ST_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_REMOVE_WR: begin
					// entry idx+1 lands at idx
					idx_q <= idx_q + CW'(1);
					if (idx_q + CW'(2) == cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q          <= 1'b1;
						res_q.status         <= status_q;
						res_q.position       <= pos_ext[5:0];
						res_q.found_capacity <= fcap_q;
						res_q.found_cost     <= fcost_q;
						res_q.entry_count    <= cnt_ext[6:0];
						res_q.is_empty       <= (cnt_q == '0);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign op_ready  = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ sim/tb_ordered_edge_list_table.sv @@
// testbench for the ordered edge list table: tracking scoreboard, directed and random beats

// mirrors the list contents and queues the result beat each accepted operation must produce
class edge_list_tracker;
	logic [11:0]        slot_vertex   [oelt_pkg::LIST_DEPTH_DEF];
	logic [15:0]        slot_capacity [oelt_pkg::LIST_DEPTH_DEF];
	logic signed [15:0] slot_cost     [oelt_pkg::LIST_DEPTH_DEF];
	int                 fill;
	oelt_pkg::res_t     due_results [$];
	int unsigned        taken;
	int unsigned        checked;
	int unsigned        errors;
	int unsigned        n_kind [4];
	int unsigned        full_rejects;
	int unsigned        not_found;
	int unsigned        empties;
	int                 peak;

	// apply one accepted operation to the mirror and queue its result
	function void take_op(oelt_pkg::op_t o);
		oelt_pkg::res_t r;
		int             slot;
		r = '0;
		taken++;
		n_kind[o.kind]++;
		if (o.kind == oelt_pkg::KIND_FRONT || o.kind == oelt_pkg::KIND_BACK) begin
			if (fill >= int'(oelt_pkg::LIST_DEPTH_DEF)) begin
				r.status = oelt_pkg::STATUS_FULL;
				full_rejects++;
			end else begin
				slot = (o.kind == oelt_pkg::KIND_FRONT) ? 0 : fill;
				for (int i = fill; i > slot; i--) begin
					slot_vertex[i]   = slot_vertex[i - 1];
					slot_capacity[i] = slot_capacity[i - 1];
					slot_cost[i]     = slot_cost[i - 1];
				end
				slot_vertex[slot]   = o.vertex;
				slot_capacity[slot] = o.capacity;
				slot_cost[slot]     = o.cost;
				fill++;
				r.status   = oelt_pkg::STATUS_OK;
				r.position = 6'(slot);
			end
		end else begin
			// first match from the front wins
			slot = fill;
			for (int i = fill - 1; i >= 0; i--)
				if (slot_vertex[i] == o.vertex)
					slot = i;
			if (slot == fill) begin
				r.status = oelt_pkg::STATUS_MISSING;
				not_found++;
			end else begin
				r.status         = oelt_pkg::STATUS_OK;
				r.position       = 6'(slot);
				r.found_capacity = slot_capacity[slot];
				r.found_cost     = slot_cost[slot];
				if (o.kind == oelt_pkg::KIND_REMOVE) begin
					for (int i = slot; i + 1 < fill; i++) begin
						slot_vertex[i]   = slot_vertex[i + 1];
						slot_capacity[i] = slot_capacity[i + 1];
						slot_cost[i]     = slot_cost[i + 1];
					end
					fill--;
					if (fill == 0)
						empties++;
				end
			end
		end
		if (fill > peak)
			peak = fill;
		r.entry_count = 7'(fill);
		r.is_empty    = (fill == 0);
		due_results.push_back(r);
	endfunction

	task report(string what);
		$display("mismatch at result %0d: %s", checked, what);
		errors++;
	endtask

	task check_result(oelt_pkg::res_t got);
		oelt_pkg::res_t want;
		if (due_results.size() == 0) begin
			report($sformatf("result beat with nothing pending (status %0d position %0d)",
				got.status, got.position));
			return;
		end
		want = due_results.pop_front();
		checked++;
		if (got.status !== want.status)
			report($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.position !== want.position)
			report($sformatf("position %0d, expected %0d", got.position, want.position));
		if (got.found_capacity !== want.found_capacity)
			report($sformatf("found_capacity %0d, expected %0d",
				got.found_capacity, want.found_capacity));
		if (got.found_cost !== want.found_cost)
			report($sformatf("found_cost %0d, expected %0d", got.found_cost, want.found_cost));
		if (got.entry_count !== want.entry_count)
			report($sformatf("entry_count %0d, expected %0d",
				got.entry_count, want.entry_count));
		if (got.is_empty !== want.is_empty)
			report($sformatf("is_empty %0d, expected %0d", got.is_empty, want.is_empty));
	endtask
endclass

module tb_ordered_edge_list_table;

	localparam int ITEM_TARGET   = 1400;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int IDLE_PCT      = 14;
	// longest single operation is a full walk of the list, so wait well past it
	localparam int SETTLE_CYCLES = oelt_pkg::LIST_DEPTH_DEF + 40;

	// what a random phase steers toward before it ends
	localparam int GOAL_NONE  = 0;
	localparam int GOAL_FULL  = 1;
	localparam int GOAL_EMPTY = 2;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           op_valid;
	logic           op_ready;
	oelt_pkg::op_t  op;
	logic           res_valid;
	logic           res_ready;
	oelt_pkg::res_t res;

	// idling switches, turned off for one random phase
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;

	int unsigned      cycles = 0;
	edge_list_tracker tracker = new();

	ordered_edge_list_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycles, tracker.due_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// result side: check every accepted beat, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			tracker.check_result(res);
		res_ready <= !(recv_idle && $urandom_range(99) < IDLE_PCT);
	end

	// present one operation beat and hold it until the block takes it;
	// an optional gap drops valid first, never in the same step it is raised
	task automatic send_op(input oelt_pkg::op_t o);
		while (send_idle && $urandom_range(99) < IDLE_PCT) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op       <= o;
		op_valid <= 1'b1;
		@(posedge clk);
		while (!op_ready)
			@(posedge clk);
		tracker.take_op(o);
	endtask

	task automatic send_fields(input logic [1:0] k, input int v, input int c, input int s);
		oelt_pkg::op_t o;
		o.kind     = k;
		o.vertex   = 12'(v);
		o.capacity = 16'(c);
		o.cost     = 16'(s);
		send_op(o);
	endtask

	// hold off the sender until every pending result has come back
	task automatic wait_drained();
		op_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.due_results.size() != 0);
	endtask

	// random operation with weighted kind; vertices come mostly from the live list
	// or a tiny pool so that hits and duplicates are common
	function automatic oelt_pkg::op_t random_op(int w_ins, int w_srch, int p_list);
		oelt_pkg::op_t o;
		int            roll;
		roll = $urandom_range(99);
		if (roll < w_ins)
			o.kind = $urandom_range(1) ? oelt_pkg::KIND_FRONT : oelt_pkg::KIND_BACK;
		else if (roll < w_ins + w_srch)
			o.kind = oelt_pkg::KIND_SEARCH;
		else
			o.kind = oelt_pkg::KIND_REMOVE;
		roll = $urandom_range(99);
		if (roll < p_list && tracker.fill > 0)
			o.vertex = tracker.slot_vertex[$urandom_range(tracker.fill - 1)];
		else if (roll < p_list + (100 - p_list) / 2)
			o.vertex = 12'($urandom_range(7));
		else
			o.vertex = 12'($urandom_range(4095));
		case ($urandom_range(15))
			0:       o.capacity = 16'h0000;
			1:       o.capacity = 16'hffff;
			default: o.capacity = 16'($urandom);
		endcase
		case ($urandom_range(15))
			0:       o.cost = 16'sh8000;
			1:       o.cost = 16'sh7fff;
			default: o.cost = 16'($urandom);
		endcase
		return o;
	endfunction

	task automatic run_phase(int w_ins, int w_srch, int p_list, int max_items, int goal);
		int n;
		int rejects0;
		n        = 0;
		rejects0 = tracker.full_rejects;
		while (n < max_items && tracker.taken < ITEM_TARGET) begin
			send_op(random_op(w_ins, w_srch, p_list));
			n++;
			// a few list-full rejects are enough before turning around
			if (goal == GOAL_FULL && tracker.full_rejects >= rejects0 + 4)
				break;
			if (goal == GOAL_EMPTY && tracker.fill == 0 && n > 8)
				break;
		end
	endtask

	initial begin
		int phase_no;
		arst_n    <= 1'b0;
		op_valid  <= 1'b0;
		op        <= '0;
		res_ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses on an empty list, field extremes, duplicates,
		// removal at front, middle and back, and single-entry lists
		send_fields(oelt_pkg::KIND_SEARCH, 5, 16'h1234, 77);
		send_fields(oelt_pkg::KIND_REMOVE, 5, 16'hffff, -1);
		send_fields(oelt_pkg::KIND_BACK,   0,     0,      -32768);
		send_fields(oelt_pkg::KIND_BACK,   4095,  65535,  32767);
		send_fields(oelt_pkg::KIND_FRONT,  'haaa, 'h5555, -21846);
		send_fields(oelt_pkg::KIND_FRONT,  'h555, 'haaaa, 21845);
		send_fields(oelt_pkg::KIND_BACK,   'h555, 'h0f0f, -3856);
		// list now, from the front: 555 aaa 0 fff 555
		send_fields(oelt_pkg::KIND_SEARCH, 'h555, 0, 0);
		send_fields(oelt_pkg::KIND_SEARCH, 4095,  'hffff, -1);
		send_fields(oelt_pkg::KIND_SEARCH, 0,     1, 1);
		send_fields(oelt_pkg::KIND_SEARCH, 'h123, 0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 'h555, 0, 0);
		send_fields(oelt_pkg::KIND_SEARCH, 'h555, 0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 0,     0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 'h555, 0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 'h777, 0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 'haaa, 0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 4095,  0, 0);
		send_fields(oelt_pkg::KIND_FRONT,  'h800, 'h8000, -1);
		send_fields(oelt_pkg::KIND_REMOVE, 'h800, 0, 0);
		send_fields(oelt_pkg::KIND_BACK,   1,     1, 1);
		send_fields(oelt_pkg::KIND_SEARCH, 1,     0, 0);
		send_fields(oelt_pkg::KIND_REMOVE, 1,     0, 0);
		wait_drained();

		// random: grow to full, churn, drain to empty, churn, and around again
		phase_no = 0;
		while (tracker.taken < ITEM_TARGET) begin
			send_idle = (phase_no != 1);
			recv_idle = (phase_no != 1);
			case (phase_no % 4)
				0:       run_phase(75, 15, 50, 250, GOAL_FULL);
				2:       run_phase(10, 20, 90, 250, GOAL_EMPTY);
				default: run_phase(40, 35, 60, 120, GOAL_NONE);
			endcase
			if (phase_no % 4 == 3)
				wait_drained();
			phase_no++;
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
		op_valid <= 1'b0;

		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d operation beats (front %0d, back %0d, search %0d, remove %0d),",
			tracker.taken, tracker.n_kind[oelt_pkg::KIND_FRONT],
			tracker.n_kind[oelt_pkg::KIND_BACK], tracker.n_kind[oelt_pkg::KIND_SEARCH],
			tracker.n_kind[oelt_pkg::KIND_REMOVE]);
		$display("%0d checked, %0d mismatches, %0d full rejects, %0d misses, peak %0d, %0d empties",
			tracker.checked, tracker.errors, tracker.full_rejects, tracker.not_found,
			tracker.peak, tracker.empties);
		if (tracker.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/oelt_pkg.sv
sv/oelt_store.sv
sv/ordered_edge_list_table.sv
sim/tb_ordered_edge_list_table.sv
